// File: rtl/core/spd_pkg.sv
package spd_pkg;

  localparam int PAGE_SIZE  = 4096;
  localparam int SLOT_CAP   = 1024;
  localparam int HDR_BYTES  = 4;
  localparam int SLOT_BYTES = 4;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 13;
  localparam int STAT_W = 3;
  localparam int ADDR_W = $clog2(SLOT_CAP);
  localparam int CNT_W  = $clog2(SLOT_CAP + 1);
  localparam int FE_W   = 13;
  // wide enough for record length plus a full directory
  localparam int NEED_W = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_OUT_RANGE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] slot_index;
    logic [LEN_W-1:0] tuple_length;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  new_slot_index;
    logic [LEN_W-1:0]  tuple_offset;
    logic [LEN_W-1:0]  stored_length;
    logic [LEN_W-1:0]  free_bytes;
  } out_t;

  typedef struct packed {
    logic [FE_W-1:0]  offset;
    logic [LEN_W-1:0] length;
  } slot_ent_t;

endpackage

// File: rtl/core/slotted_page_directory.sv
// Slot directory of a slotted page: init, insert, update (shrink only), get and delete
// requests each give one result. A request is taken every cycle when the result side
// keeps up. The slot memory is read at the edge that takes the request (one read port,
// registered data); the evaluate stage then computes the result, writes the slot entry
// back and loads the result register, but waits while a stalled result blocks it. A
// request that reads the slot its predecessor writes in the same cycle gets the written
// entry by a bypass.
module slotted_page_directory import spd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  slot_ent_t slot_mem_r [SLOT_CAP];

  logic             ex_valid_r;
  in_t              req_r;
  slot_ent_t        rd_data_r;
  logic             fwd_hit_r;
  slot_ent_t        fwd_data_r;
  logic [CNT_W-1:0] total_r;
  logic [FE_W-1:0]  free_end_r;
  logic             out_valid_r;
  out_t             out_r;

  logic             ex_block;
  logic             ex_adv;
  logic             in_accept;
  slot_ent_t        ent;
  logic [CNT_W-1:0] total_nxt;
  logic [FE_W-1:0]  free_end_nxt;
  out_t             res;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  slot_ent_t        wr_data;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] dir_end;
  logic             in_range;

  assign ex_block  = out_valid_r && out_stall;
  assign ex_adv    = ex_valid_r && !ex_block;
  assign in_stall  = ex_valid_r && ex_block;
  assign in_accept = in_valid && !in_stall;

  assign ent = fwd_hit_r ? fwd_data_r : rd_data_r;

  assign need = NEED_W'(req_r.tuple_length) + NEED_W'(HDR_BYTES)
              + (NEED_W'(total_r) + NEED_W'(1)) * NEED_W'(SLOT_BYTES);
  assign in_range = CNT_W'(req_r.slot_index) < total_r;

  always_comb begin
    total_nxt    = total_r;
    free_end_nxt = free_end_r;
    wr_en        = 1'b0;
    wr_addr      = ADDR_W'(req_r.slot_index);
    wr_data      = ent;
    res          = '0;
    res.status   = ST_OK;
    unique case (req_r.cmd)
      CMD_INIT: begin
        total_nxt    = '0;
        free_end_nxt = FE_W'(PAGE_SIZE);
      end
      CMD_INSERT: begin
        if (total_r >= CNT_W'(SLOT_CAP) || need > NEED_W'(free_end_r)) begin
          res.status = ST_NO_SPACE;
        end else begin
          free_end_nxt         = free_end_r - FE_W'(req_r.tuple_length);
          total_nxt            = total_r + CNT_W'(1);
          wr_en                = 1'b1;
          wr_addr              = total_r[ADDR_W-1:0];
          wr_data.offset       = free_end_nxt;
          wr_data.length       = req_r.tuple_length;
          res.new_slot_index   = IDX_W'(total_r[ADDR_W-1:0]);
          res.tuple_offset     = LEN_W'(free_end_nxt);
          res.stored_length    = req_r.tuple_length;
        end
      end
      CMD_UPDATE, CMD_GET, CMD_DELETE: begin
        priority if (!in_range) begin
          res.status = ST_OUT_RANGE;
        end else if (ent.length == '0) begin
          res.status = ST_EMPTY;
        end else if (req_r.cmd == CMD_UPDATE) begin
          if (req_r.tuple_length > ent.length) begin
            res.status = ST_TOO_LONG;
          end else begin
            wr_en             = 1'b1;
            wr_data.length    = req_r.tuple_length;
            res.tuple_offset  = LEN_W'(ent.offset);
            res.stored_length = req_r.tuple_length;
          end
        end else if (req_r.cmd == CMD_GET) begin
          res.tuple_offset  = LEN_W'(ent.offset);
          res.stored_length = ent.length;
        end else begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
      end
      default: begin
      end
    endcase
    wr_en = wr_en && ex_adv;
    dir_end = NEED_W'(HDR_BYTES) + NEED_W'(total_nxt) * NEED_W'(SLOT_BYTES);
    res.free_bytes = (dir_end > NEED_W'(free_end_nxt)) ? '0
                   : LEN_W'(NEED_W'(free_end_nxt) - dir_end);
  end

  // slot memory: one write, one registered read, bypass for same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      rd_data_r  <= slot_mem_r[ADDR_W'(in_data.slot_index)];
      fwd_hit_r  <= wr_en && (wr_addr == ADDR_W'(in_data.slot_index));
      fwd_data_r <= wr_data;
      req_r      <= in_data;
    end
    if (ex_adv) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      free_end_r  <= FE_W'(PAGE_SIZE);
    end else begin
      if (in_accept) begin
        ex_valid_r <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
        free_end_r  <= free_end_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/spd_checker.sv
module spd_checker import spd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // a stalled request stays offered unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // a failing request reports nothing but status and free space
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.new_slot_index == '0 && out_data.tuple_offset == '0 &&
      out_data.stored_length == '0)
    else $error("failed request carries slot data");

  // free space never exceeds the page minus its header
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_bytes <= LEN_W'(PAGE_SIZE - HDR_BYTES))
    else $error("free space out of bounds");

endmodule

bind slotted_page_directory spd_checker u_spd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/testbench.sv
module testbench;
  import spd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  slotted_page_directory u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // own copy of the page directory
  logic [CNT_W-1:0] dir_slots;
  logic [FE_W-1:0]  dir_free_end;
  logic [LEN_W-1:0] dir_off [SLOT_CAP];
  logic [LEN_W-1:0] dir_len [SLOT_CAP];

  out_t pending_results[$];
  int   err_count;
  int   requests_sent;
  int   results_seen;
  int   cycle_count;
  bit   idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic out_t next_page_result(input in_t req);
    out_t res;
    int   need;
    logic [ADDR_W-1:0] idx;
    res = '0;
    idx = req.slot_index;
    case (req.cmd)
      CMD_INIT: begin
        dir_slots    = '0;
        dir_free_end = FE_W'(PAGE_SIZE);
      end
      CMD_INSERT: begin
        need = int'(req.tuple_length) + HDR_BYTES + (int'(dir_slots) + 1) * SLOT_BYTES;
        if (int'(dir_slots) >= SLOT_CAP || need > int'(dir_free_end)) begin
          res.status = ST_NO_SPACE;
        end else begin
          dir_free_end                        = dir_free_end - req.tuple_length;
          dir_off[dir_slots[ADDR_W-1:0]]      = dir_free_end;
          dir_len[dir_slots[ADDR_W-1:0]]      = req.tuple_length;
          res.new_slot_index                  = dir_slots[IDX_W-1:0];
          res.tuple_offset                    = dir_free_end;
          res.stored_length                   = req.tuple_length;
          dir_slots                           = dir_slots + 1'b1;
        end
      end
      CMD_UPDATE, CMD_GET, CMD_DELETE: begin
        if (CNT_W'(idx) >= dir_slots) begin
          res.status = ST_OUT_RANGE;
        end else if (dir_len[idx] == '0) begin
          res.status = ST_EMPTY;
        end else if (req.cmd == CMD_UPDATE) begin
          if (req.tuple_length > dir_len[idx]) begin
            res.status = ST_TOO_LONG;
          end else begin
            dir_len[idx]      = req.tuple_length;
            res.tuple_offset  = dir_off[idx];
            res.stored_length = req.tuple_length;
          end
        end else if (req.cmd == CMD_GET) begin
          res.tuple_offset  = dir_off[idx];
          res.stored_length = dir_len[idx];
        end else begin
          dir_off[idx] = '0;
          dir_len[idx] = '0;
        end
      end
      default: begin
      end
    endcase
    // directory end never passes free end, clamp kept anyway
    need = HDR_BYTES + int'(dir_slots) * SLOT_BYTES;
    res.free_bytes = (need > int'(dir_free_end)) ? '0 : LEN_W'(int'(dir_free_end) - need);
    return res;
  endfunction

  // valid is left high on return; a wait lowers it, the next call only for an idle gap
  task automatic send_request(input logic [CMD_W-1:0] cmd, input int idx, input int len);
    in_t req;
    req.cmd          = cmd;
    req.slot_index   = IDX_W'(idx);
    req.tuple_length = LEN_W'(len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(next_page_result(req));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no request pending", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, want %0d",
                                results_seen, got.status, want.status));
    if (got.new_slot_index !== want.new_slot_index)
      report_mismatch($sformatf("result %0d new_slot_index %0d, want %0d",
                                results_seen, got.new_slot_index, want.new_slot_index));
    if (got.tuple_offset !== want.tuple_offset)
      report_mismatch($sformatf("result %0d tuple_offset %0d, want %0d",
                                results_seen, got.tuple_offset, want.tuple_offset));
    if (got.stored_length !== want.stored_length)
      report_mismatch($sformatf("result %0d stored_length %0d, want %0d",
                                results_seen, got.stored_length, want.stored_length));
    if (got.free_bytes !== want.free_bytes)
      report_mismatch($sformatf("result %0d free_bytes %0d, want %0d",
                                results_seen, got.free_bytes, want.free_bytes));
    results_seen++;
  endtask

  // result side: check on accept, then pick the stall for the next cycle
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 150);
    if (r < 90) return $urandom_range(151, 1500);
    if (r < 98) return $urandom_range(1501, PAGE_SIZE);
    return $urandom_range(PAGE_SIZE + 1, LEN_MAX);
  endfunction

  task automatic test_empty_page();
    send_request(CMD_INIT, 0, 0);
    send_request(CMD_GET, 0, 0);
    send_request(CMD_UPDATE, 0, 0);
    send_request(CMD_DELETE, IDX_MAX, LEN_MAX);
    send_request(CMD_RSVD_FIRST, 0, 0);
    send_request(CMD_RSVD_LAST, IDX_MAX, LEN_MAX);
  endtask

  task automatic test_insert_limits();
    // zero-length record gets a slot that then reads as empty
    send_request(CMD_INSERT, IDX_MAX, 0);
    send_request(CMD_GET, 0, 0);
    send_request(CMD_UPDATE, 0, 0);
    send_request(CMD_DELETE, 0, 0);
    send_request(CMD_INSERT, 0, LEN_MAX);
    // one byte over, then exactly filling the page
    send_request(CMD_INSERT, 0, PAGE_SIZE - 11);
    send_request(CMD_INSERT, 0, PAGE_SIZE - 12);
    send_request(CMD_INSERT, 0, 0);
    send_request(CMD_UPDATE, 1, PAGE_SIZE - 11);
    send_request(CMD_UPDATE, 1, PAGE_SIZE - 12);
    send_request(CMD_UPDATE, 1, 1);
    send_request(CMD_GET, 1, LEN_MAX);
    send_request(CMD_DELETE, 1, 0);
    send_request(CMD_GET, 1, 0);
    send_request(CMD_GET, 2, 0);
    send_request(CMD_INIT, IDX_MAX, LEN_MAX);
    send_request(CMD_GET, 0, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input bit tiny_records);
    int r;
    int idx;
    int len;
    logic [CMD_W-1:0] cmd;
    repeat (n_items) begin
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, IDX_MAX);
      len = $urandom_range(0, LEN_MAX);
      if (r < 2) begin
        cmd = CMD_INIT;
      end else if (r < (tiny_records ? 70 : 45)) begin
        cmd = CMD_INSERT;
        len = tiny_records ? $urandom_range(0, 3) : pick_length();
      end else if (r < 95) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_UPDATE;
          1:       cmd = CMD_GET;
          default: cmd = CMD_DELETE;
        endcase
        // mostly address live slots, sometimes anything
        if (dir_slots != '0 && $urandom_range(0, 9) != 0) begin
          idx = $urandom_range(0, int'(dir_slots) - 1);
          if ($urandom_range(0, 7) != 0)
            len = $urandom_range(0, int'(dir_len[ADDR_W'(idx)]) + 3);
        end
      end else begin
        cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      end
      send_request(cmd, idx, len);
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    err_count     = 0;
    requests_sent = 0;
    results_seen  = 0;
    idle_on       = 1'b1;
    dir_slots     = '0;
    dir_free_end  = FE_W'(PAGE_SIZE);
    for (int i = 0; i < SLOT_CAP; i++) begin
      dir_off[ADDR_W'(i)] = '0;
      dir_len[ADDR_W'(i)] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_page();
    test_insert_limits();
    wait_all_results();
    test_random_traffic(250, 1'b0);
    wait_all_results();
    test_random_traffic(150, 1'b1);
    idle_on = 1'b0;
    test_random_traffic(200, 1'b0);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d page requests, checked %0d results in %0d cycles",
             requests_sent, results_seen, cycle_count);
    $display("covered init, insert up to a full page, shrink, get, delete, reserved codes");
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
